/* rtl/core/blf_pkg.sv */
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types, codes and the gamma table for the backlight fader and
// indicator LED pulser.
// ----------------------------------------------------------------------------
package blf_pkg;

   localparam int GAMMA_ENTRIES = 64;
   localparam int GAMMA_IDX_W   = $clog2(GAMMA_ENTRIES);
   localparam int PHASE_W       = 16;
   localparam int GAMMA_LSB     = 5;   // phase bits [10:5] pick the table entry
   localparam int BLINK_BIT     = 11;  // phase bit 11 (2048) mirrors / blinks
   localparam int FADE_TICK_W   = 4;   // fade step when ms_count[3:0] == 0

   localparam logic [7:0] BRIGHTNESS_RESET = 8'd13;
   localparam logic [7:0] LEVEL_FULL       = 8'd255;
   localparam logic [7:0] LEVEL_ZERO       = 8'd0;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_DIM_LEVEL      = 3'd0,
      CSR_BRIGHT_LEVEL   = 3'd1,
      CSR_FADE_UP_STEP   = 3'd2,
      CSR_FADE_DOWN_STEP = 3'd3,
      CSR_TIMEOUT_SECS   = 3'd4
   } csr_idx_type;

   localparam logic [7:0] DIM_LEVEL_RESET      = 8'd13;
   localparam logic [7:0] BRIGHT_LEVEL_RESET   = 8'd255;
   localparam logic [7:0] FADE_UP_STEP_RESET   = 8'd42;
   localparam logic [7:0] FADE_DOWN_STEP_RESET = 8'd3;
   localparam logic [7:0] TIMEOUT_SECS_RESET   = 8'd30;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_WAKE      = 3'd1,
      OP_PULSE     = 3'd2,
      OP_BLINK     = 3'd3,
      OP_STOP      = 3'd4,
      OP_IND_OFF   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      BL_IDLE = 2'd0,
      BL_UP   = 2'd1,
      BL_DOWN = 2'd2
   } bl_mode_type;

   typedef enum logic [1:0] {
      IND_OFF   = 2'd0,
      IND_PULSE = 2'd1,
      IND_BLINK = 2'd2
   } ind_mode_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] indicator_rate;
   } req_type;

   typedef struct packed {
      logic [7:0] backlight_level;
      logic       backlight_changed;
      logic [7:0] indicator_level;
      logic       indicator_changed;
   } rsp_type;

   typedef struct packed {
      logic [7:0] dim_level;
      logic [7:0] bright_level;
      logic [7:0] fade_up_step;
      logic [7:0] fade_down_step;
      logic [7:0] backlight_timeout_secs;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         backlight_brightness;
      bl_mode_type        backlight_mode;
      logic [7:0]         timeout_count;
      logic [PHASE_W-1:0] indicator_phase;
      ind_mode_type       indicator_mode;
      logic [7:0]         indicator_step;
      logic [7:0]         ms_count;
      logic [1:0]         quarter_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      backlight_brightness: BRIGHTNESS_RESET,
      backlight_mode:       BL_IDLE,
      timeout_count:        8'd0,
      indicator_phase:      '0,
      indicator_mode:       IND_OFF,
      indicator_step:       8'd0,
      ms_count:             8'd0,
      quarter_count:        2'd0
   };

   localparam logic [7:0] GAMMA_ROM [GAMMA_ENTRIES] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
      8'd3,   8'd4,   8'd4,   8'd5,   8'd7,   8'd8,   8'd9,   8'd11,
      8'd13,  8'd14,  8'd16,  8'd18,  8'd20,  8'd23,  8'd25,  8'd28,
      8'd31,  8'd33,  8'd36,  8'd40,  8'd43,  8'd46,  8'd50,  8'd54,
      8'd57,  8'd61,  8'd66,  8'd70,  8'd74,  8'd79,  8'd84,  8'd89,
      8'd94,  8'd99,  8'd105, 8'd110, 8'd116, 8'd122, 8'd128, 8'd134,
      8'd140, 8'd147, 8'd153, 8'd160, 8'd167, 8'd174, 8'd182, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd221, 8'd229, 8'd238, 8'd246, 8'd255
   };

endpackage

/* rtl/core/blf_update.sv */
// ----------------------------------------------------------------------------
// blf_update
// Next-state and result logic for one word: tick bookkeeping, fade step,
// backlight wake and indicator commands.
// ----------------------------------------------------------------------------
module blf_update (
   input  blf_pkg::state_type cur,
   input  blf_pkg::cfg_type   cfg,
   input  blf_pkg::req_type   req,
   output blf_pkg::state_type nxt,
   output blf_pkg::rsp_type   rsp
);

   logic                            fade_go;
   logic [8:0]                      up_sum;
   logic [8:0]                      dim_sum;
   logic [blf_pkg::PHASE_W-1:0]     phase_adv;
   logic [blf_pkg::GAMMA_IDX_W-1:0] gidx;
   logic [7:0]                      ms_next;
   logic [1:0]                      qtr_next;
   logic [7:0]                      tmo_dec;
   logic                            bl_w;
   logic                            ind_w;
   logic [7:0]                      ind_val;
   blf_pkg::ind_mode_type           want;

   assign up_sum    = {1'b0, cur.backlight_brightness} + {1'b0, cfg.fade_up_step};
   assign dim_sum   = {1'b0, cfg.dim_level} + {1'b0, cfg.fade_down_step};
   assign phase_adv = cur.indicator_phase
                      + {{(blf_pkg::PHASE_W-8){1'b0}}, cur.indicator_step};
   assign ms_next   = cur.ms_count + 8'd1;
   assign qtr_next  = cur.quarter_count + 2'd1;
   assign tmo_dec   = cur.timeout_count - 8'd1;

   // mirrored table index in the second half of each period
   always_comb begin
      gidx = phase_adv[blf_pkg::GAMMA_LSB +: blf_pkg::GAMMA_IDX_W];
      if (phase_adv[blf_pkg::BLINK_BIT]) begin
         gidx = ~gidx;
      end
   end

   assign fade_go = !(cur.backlight_mode == blf_pkg::BL_IDLE &&
                      cur.indicator_mode == blf_pkg::IND_OFF) &&
                    (cur.ms_count[blf_pkg::FADE_TICK_W-1:0] == '0);

   assign want = (req.operation == blf_pkg::OP_PULSE) ? blf_pkg::IND_PULSE
                                                       : blf_pkg::IND_BLINK;

   always_comb begin
      nxt     = cur;
      bl_w    = 1'b0;
      ind_w   = 1'b0;
      ind_val = blf_pkg::LEVEL_ZERO;
      case (blf_pkg::op_type'(req.operation))
         blf_pkg::OP_TICK: begin
            if (fade_go) begin
               if (cur.backlight_mode == blf_pkg::BL_UP) begin
                  bl_w = 1'b1;
                  if (up_sum < {1'b0, cfg.bright_level}) begin
                     nxt.backlight_brightness = up_sum[7:0];
                  end else begin
                     nxt.backlight_brightness = cfg.bright_level;
                     nxt.backlight_mode       = blf_pkg::BL_IDLE;
                  end
               end else if (cur.backlight_mode == blf_pkg::BL_DOWN) begin
                  bl_w = 1'b1;
                  if ({1'b0, cur.backlight_brightness} > dim_sum) begin
                     nxt.backlight_brightness = cur.backlight_brightness
                                                - cfg.fade_down_step;
                  end else begin
                     nxt.backlight_brightness = cfg.dim_level;
                     nxt.backlight_mode       = blf_pkg::BL_IDLE;
                  end
               end
               if (cur.indicator_mode != blf_pkg::IND_OFF) begin
                  ind_w               = 1'b1;
                  nxt.indicator_phase = phase_adv;
                  if (cur.indicator_mode == blf_pkg::IND_BLINK) begin
                     ind_val = phase_adv[blf_pkg::BLINK_BIT] ? blf_pkg::LEVEL_ZERO
                                                             : blf_pkg::LEVEL_FULL;
                  end else begin
                     ind_val = blf_pkg::GAMMA_ROM[gidx];
                  end
               end
            end
            nxt.ms_count = ms_next;
            if (ms_next == 8'd0) begin
               nxt.quarter_count = qtr_next;
               // one second every four wraps of the ms counter
               if (qtr_next == 2'd0 && cur.timeout_count != 8'd0) begin
                  nxt.timeout_count = tmo_dec;
                  if (tmo_dec == 8'd0) begin
                     nxt.backlight_mode = blf_pkg::BL_DOWN;
                  end
               end
            end
         end
         blf_pkg::OP_WAKE: begin
            if (cur.timeout_count == 8'd0) begin
               nxt.backlight_mode = blf_pkg::BL_UP;
            end
            nxt.timeout_count = cfg.backlight_timeout_secs;
         end
         blf_pkg::OP_PULSE, blf_pkg::OP_BLINK: begin
            if (cur.indicator_mode != want) begin
               nxt.indicator_phase = '0;
            end
            nxt.indicator_step = req.indicator_rate;
            nxt.indicator_mode = want;
         end
         blf_pkg::OP_STOP: begin
            nxt.indicator_mode = blf_pkg::IND_OFF;
         end
         blf_pkg::OP_IND_OFF: begin
            nxt.indicator_mode = blf_pkg::IND_OFF;
            ind_w              = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp.backlight_level   = nxt.backlight_brightness;
   assign rsp.backlight_changed = bl_w;
   assign rsp.indicator_level   = ind_w ? ind_val : blf_pkg::LEVEL_ZERO;
   assign rsp.indicator_changed = ind_w;

endmodule

/* rtl/core/backlight_fader_and_led_pulser.sv */
// ----------------------------------------------------------------------------
// backlight_fader_and_led_pulser
// Backlight fade controller and indicator LED pulse/blink generator driven by
// 1 ms tick words and command words.
// ----------------------------------------------------------------------------
// Usage: every request word (a 1 ms tick or a command) yields exactly one
// response word carrying the backlight duty and, when written, the indicator
// duty. The block takes one word per clock when the response side keeps up.
// An accepted word is held in the execute stage, updated against the state
// store and captured into the response register, which drives rsp_valid,
// once that register is free. The store is a single-entry synchronous
// memory read every cycle, so its read latency is hidden, and the previous
// cycle's write is forwarded so back-to-back words see fresh state. A valid
// bit stands in for the reset contents of the store, so there is no
// clearing pass after reset. The five configuration registers are written
// through the csr_ port and should only change while the block is idle.
// ----------------------------------------------------------------------------
module backlight_fader_and_led_pulser (
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_ready,
   input  blf_pkg::req_type req_data,

   output logic             rsp_valid,
   input  logic             rsp_ready,
   output blf_pkg::rsp_type rsp_data,

   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_wdata
);

   // configuration registers
   blf_pkg::cfg_type   cfg_ff;

   // state store (one entry) and its read port
   blf_pkg::state_type state_mem [1];
   blf_pkg::state_type rd_data_ff;
   logic               state_vld_ff;   // store written at least once
   logic               fwd_vld_ff;     // write landed at the same edge as the read
   blf_pkg::state_type fwd_data_ff;
   blf_pkg::state_type cur_state;
   blf_pkg::state_type nxt_state;

   // execute stage
   logic               ex_vld_ff;
   logic               ex_vld_in;
   blf_pkg::req_type   ex_req_ff;
   logic               ex_adv;

   // response register
   logic               rsp_vld_ff;
   logic               rsp_vld_in;
   blf_pkg::rsp_type   rsp_ff;
   blf_pkg::rsp_type   ex_rsp;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_level              <= blf_pkg::DIM_LEVEL_RESET;
         cfg_ff.bright_level           <= blf_pkg::BRIGHT_LEVEL_RESET;
         cfg_ff.fade_up_step           <= blf_pkg::FADE_UP_STEP_RESET;
         cfg_ff.fade_down_step         <= blf_pkg::FADE_DOWN_STEP_RESET;
         cfg_ff.backlight_timeout_secs <= blf_pkg::TIMEOUT_SECS_RESET;
      end else if (csr_wr_en) begin
         case (blf_pkg::csr_idx_type'(csr_index))
            blf_pkg::CSR_DIM_LEVEL:      cfg_ff.dim_level              <= csr_wdata;
            blf_pkg::CSR_BRIGHT_LEVEL:   cfg_ff.bright_level           <= csr_wdata;
            blf_pkg::CSR_FADE_UP_STEP:   cfg_ff.fade_up_step           <= csr_wdata;
            blf_pkg::CSR_FADE_DOWN_STEP: cfg_ff.fade_down_step         <= csr_wdata;
            blf_pkg::CSR_TIMEOUT_SECS:   cfg_ff.backlight_timeout_secs <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---------------- handshake ----------------
   // execute stage retires into the response register when that is free
   assign ex_adv     = ex_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready  = !ex_vld_ff || ex_adv;
   assign ex_vld_in  = (req_valid && req_ready) || (ex_vld_ff && !ex_adv);
   assign rsp_vld_in = ex_adv || (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         ex_vld_ff  <= ex_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ex_req_ff <= req_data;
      end
      if (ex_adv) begin
         rsp_ff <= ex_rsp;
      end
   end

   // ---------------- state store ----------------
   // read every cycle; a write at the same edge is caught by the bypass
   always_ff @(posedge clock) begin
      if (ex_adv) begin
         state_mem[0] <= nxt_state;
      end
      rd_data_ff  <= state_mem[0];
      fwd_data_ff <= nxt_state;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_vld_ff <= 1'b0;
         fwd_vld_ff   <= 1'b0;
      end else begin
         state_vld_ff <= state_vld_ff || ex_adv;
         fwd_vld_ff   <= ex_adv;
      end
   end

   always_comb begin
      if (fwd_vld_ff) begin
         cur_state = fwd_data_ff;
      end else if (state_vld_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = blf_pkg::STATE_RESET;
      end
   end

   blf_update u_update (
      .cur (cur_state),
      .cfg (cfg_ff),
      .req (ex_req_ff),
      .nxt (nxt_state),
      .rsp (ex_rsp)
   );

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sim/backlight_fader_and_led_pulser_tb.sv */
// ----------------------------------------------------------------------------
// backlight_fader_and_led_pulser_tb
// Self-checking bench for the backlight fader and indicator pulser. A short
// scripted run from reset covers every command and the corner cases. Random
// tick-heavy traffic then runs under several register settings, with
// throttling on both handshakes in the first four passes. Every response
// word is checked against the bench's own cycle-free fade and pulse model.
// ----------------------------------------------------------------------------
module backlight_fader_and_led_pulser_tb;
   import blf_pkg::*;

   // Spare operation codes: the block must ignore them.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 8;      // idle clocks after the last response
   localparam int WORDS_PER_PASS = 30;
   localparam int RANDOM_PASSES  = 6;
   localparam int CYCLE_LIMIT    = 400000; // watchdog limit for the whole run

   // ---------------------------------------------------------------------
   // DUT hookup. Every input has a known value from time zero.
   // ---------------------------------------------------------------------
   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   backlight_fader_and_led_pulser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scripted opening run. Rows with a typed duty word are checked against
   // that word; the rest go through the model. Runs from reset defaults.
   // ---------------------------------------------------------------------
   typedef struct packed {
      req_type    word;
      logic [7:0] count;   // how many times the word is sent in a row
      logic       typed;
      rsp_type    duty;
   } script_row_type;

   localparam rsp_type NO_DUTY = '0;
   localparam int SCRIPT_ROWS = 25;
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // nothing running: a tick at ms 0 does no fade step
      '{'{OP_TICK,    8'h00}, 8'd1,   1'b1, '{8'd13, 1'b0, 8'd0, 1'b0}},
      // spare codes change nothing and write nothing
      '{'{OP_SPARE_6, 8'hFF}, 8'd1,   1'b1, '{8'd13, 1'b0, 8'd0, 1'b0}},
      '{'{OP_SPARE_7, 8'h00}, 8'd1,   1'b1, '{8'd13, 1'b0, 8'd0, 1'b0}},
      // indicator off always writes a zero duty
      '{'{OP_IND_OFF, 8'hAA}, 8'd1,   1'b1, '{8'd13, 1'b0, 8'd0, 1'b1}},
      // silent stop writes nothing
      '{'{OP_STOP,    8'h55}, 8'd1,   1'b1, '{8'd13, 1'b0, 8'd0, 1'b0}},
      '{'{OP_WAKE,    8'h00}, 8'd1,   1'b1, '{8'd13, 1'b0, 8'd0, 1'b0}},
      '{'{OP_TICK,    8'h00}, 8'd15,  1'b0, NO_DUTY},
      // ms 16: first fade step, 13 + 42
      '{'{OP_TICK,    8'h00}, 8'd1,   1'b1, '{8'd55, 1'b1, 8'd0, 1'b0}},
      '{'{OP_PULSE,   8'hFF}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_TICK,    8'h00}, 8'd16,  1'b0, NO_DUTY},
      // same mode again: phase kept, new rate taken
      '{'{OP_PULSE,   8'h80}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_TICK,    8'h00}, 8'd32,  1'b0, NO_DUTY},
      '{'{OP_BLINK,   8'hFF}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_TICK,    8'h00}, 8'd48,  1'b0, NO_DUTY},
      // wake while the timeout runs: reload only
      '{'{OP_WAKE,    8'h07}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_BLINK,   8'h00}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_TICK,    8'h00}, 8'd32,  1'b0, NO_DUTY},
      '{'{OP_IND_OFF, 8'h00}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_PULSE,   8'h01}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_TICK,    8'h00}, 8'd32,  1'b0, NO_DUTY},
      '{'{OP_STOP,    8'hFF}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_TICK,    8'h00}, 8'd16,  1'b0, NO_DUTY},
      '{'{OP_BLINK,   8'h80}, 8'd1,   1'b0, NO_DUTY},
      '{'{OP_TICK,    8'hFF}, 8'd32,  1'b0, NO_DUTY},
      '{'{OP_IND_OFF, 8'hFF}, 8'd1,   1'b0, NO_DUTY}
   };

   // ---------------------------------------------------------------------
   // Fade / pulse model: its own copy of the registers and the state.
   // ---------------------------------------------------------------------
   cfg_type   fade_cfg;
   state_type fade_st;

   function automatic rsp_type next_duty_word(req_type w);
      rsp_type                duty;
      int                     level;
      ind_mode_type           want_mode;
      logic [GAMMA_IDX_W-1:0] idx;
      duty = '0;
      case (w.operation)
         OP_TICK: begin
            // fade step only on ms[3:0] == 0, and only if something runs
            if (!(fade_st.backlight_mode == BL_IDLE && fade_st.indicator_mode == IND_OFF) &&
                fade_st.ms_count[FADE_TICK_W-1:0] == '0) begin
               level = int'(fade_st.backlight_brightness);
               if (fade_st.backlight_mode == BL_UP) begin
                  // limits compared in int so bright - step cannot wrap
                  if (level < int'(fade_cfg.bright_level) - int'(fade_cfg.fade_up_step)) begin
                     fade_st.backlight_brightness = 8'(level + int'(fade_cfg.fade_up_step));
                  end else begin
                     fade_st.backlight_brightness = fade_cfg.bright_level;
                     fade_st.backlight_mode = BL_IDLE;
                  end
                  duty.backlight_changed = 1'b1;
               end else if (fade_st.backlight_mode == BL_DOWN) begin
                  if (level > int'(fade_cfg.dim_level) + int'(fade_cfg.fade_down_step)) begin
                     fade_st.backlight_brightness = 8'(level - int'(fade_cfg.fade_down_step));
                  end else begin
                     fade_st.backlight_brightness = fade_cfg.dim_level;
                     fade_st.backlight_mode = BL_IDLE;
                  end
                  duty.backlight_changed = 1'b1;
               end
               if (fade_st.indicator_mode != IND_OFF) begin
                  fade_st.indicator_phase += PHASE_W'(fade_st.indicator_step);
                  if (fade_st.indicator_mode == IND_BLINK) begin
                     duty.indicator_level =
                        fade_st.indicator_phase[BLINK_BIT] ? LEVEL_ZERO : LEVEL_FULL;
                  end else begin
                     // second half of the period walks the table backwards
                     idx = fade_st.indicator_phase[GAMMA_LSB +: GAMMA_IDX_W];
                     if (fade_st.indicator_phase[BLINK_BIT]) idx = ~idx;
                     duty.indicator_level = GAMMA_ROM[idx];
                  end
                  duty.indicator_changed = 1'b1;
               end
            end
            fade_st.ms_count += 8'd1;
            if (fade_st.ms_count == '0) begin
               fade_st.quarter_count += 2'd1;
               if (fade_st.quarter_count == '0 && fade_st.timeout_count != '0) begin
                  fade_st.timeout_count -= 8'd1;
                  if (fade_st.timeout_count == '0) fade_st.backlight_mode = BL_DOWN;
               end
            end
         end
         OP_WAKE: begin
            if (fade_st.timeout_count == '0) fade_st.backlight_mode = BL_UP;
            fade_st.timeout_count = fade_cfg.backlight_timeout_secs;
         end
         OP_PULSE, OP_BLINK: begin
            want_mode = (w.operation == OP_PULSE) ? IND_PULSE : IND_BLINK;
            if (fade_st.indicator_mode != want_mode) fade_st.indicator_phase = '0;
            fade_st.indicator_step = w.indicator_rate;
            fade_st.indicator_mode = want_mode;
         end
         OP_STOP: begin
            fade_st.indicator_mode = IND_OFF;
         end
         OP_IND_OFF: begin
            fade_st.indicator_mode = IND_OFF;
            duty.indicator_level = LEVEL_ZERO;
            duty.indicator_changed = 1'b1;
         end
         default: ;
      endcase
      duty.backlight_level = fade_st.backlight_brightness;
      return duty;
   endfunction

   // Expected response words, oldest first.
   rsp_type duty_queue [$];

   int unsigned send_idle_pct = 12;
   int unsigned recv_idle_pct = 53;
   int unsigned words_sent    = 0;
   int unsigned words_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count   = 0;
   rsp_type     want_duty;

   // Tick-heavy mix: fades and pulses only move on ticks.
   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      pick = $urandom_range(99);
      w.indicator_rate = 8'($urandom_range(255));
      if      (pick < 82) w.operation = OP_TICK;
      else if (pick < 86) w.operation = OP_WAKE;
      else if (pick < 90) w.operation = OP_PULSE;
      else if (pick < 94) w.operation = OP_BLINK;
      else if (pick < 96) w.operation = OP_STOP;
      else if (pick < 98) w.operation = OP_IND_OFF;
      else                w.operation = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
      return w;
   endfunction

   // Register plan per random pass: extremes, inverted limits, defaults, random
   // values, oversized steps, and a zero step where the fade may never settle.
   function automatic cfg_type pass_settings(int pass);
      cfg_type s;
      case (pass)
         1: s = '{8'd0, 8'd255, 8'd1, 8'd1, 8'd1};
         2: s = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd255};
         3: s = '{DIM_LEVEL_RESET, BRIGHT_LEVEL_RESET, FADE_UP_STEP_RESET,
                  FADE_DOWN_STEP_RESET, 8'd1};
         4: s = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                  8'($urandom_range(3, 1))};
         5: s = '{8'd100, 8'd200, 8'd255, 8'd255, 8'd1};
         default: s = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'd0, 8'd0, 8'($urandom_range(255, 1))};
      endcase
      return s;
   endfunction

   // All five registers, back to back; the block is idle when this runs.
   task automatic apply_settings(cfg_type s);
      logic [7:0] vals [5];
      vals = '{s.dim_level, s.bright_level, s.fade_up_step, s.fade_down_step,
               s.backlight_timeout_secs};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      fade_cfg = s;
   endtask

   // Present one word, hold it until taken, then queue its expected duty.
   // Valid is left high so a following word goes out with no gap.
   task automatic send_word(req_type w, logic typed, rsp_type typed_duty);
      rsp_type duty;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      duty = next_duty_word(w);
      duty_queue.push_back(typed ? typed_duty : duty);
      words_sent++;
   endtask

   // Wait for every expected word, then let the pipeline empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (duty_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure and the check against the queue.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (duty_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected response word %p", rsp_data);
            end else begin
               want_duty = duty_queue.pop_front();
               words_checked++;
               if (rsp_data.backlight_level   !== want_duty.backlight_level   ||
                   rsp_data.backlight_changed !== want_duty.backlight_changed ||
                   rsp_data.indicator_level   !== want_duty.indicator_level   ||
                   rsp_data.indicator_changed !== want_duty.indicator_changed) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ERROR: word %0d bl %0d/%0d chg %0b/%0b ind %0d/%0d chg %0b/%0b",
                              words_checked,
                              rsp_data.backlight_level, want_duty.backlight_level,
                              rsp_data.backlight_changed, want_duty.backlight_changed,
                              rsp_data.indicator_level, want_duty.indicator_level,
                              rsp_data.indicator_changed, want_duty.indicator_changed);
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      fade_cfg = '{DIM_LEVEL_RESET, BRIGHT_LEVEL_RESET, FADE_UP_STEP_RESET,
                   FADE_DOWN_STEP_RESET, TIMEOUT_SECS_RESET};
      fade_st  = STATE_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scripted run on reset settings, sender light, receiver heavy
      for (int r = 0; r < SCRIPT_ROWS; r++)
         for (int k = 0; k < int'(SCRIPT[r].count); k++)
            send_word(SCRIPT[r].word, SCRIPT[r].typed, SCRIPT[r].duty);
      drain();

      // random passes: two per throttling mode; state carries over so the
      // tick counters keep advancing toward the timeout roll-over
      for (int pass = 1; pass <= RANDOM_PASSES; pass++) begin
         case ((pass - 1) / 2)
            0: begin send_idle_pct = 12; recv_idle_pct = 53; end
            1: begin send_idle_pct = 53; recv_idle_pct = 12; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         apply_settings(pass_settings(pass));
         for (int n = 0; n < WORDS_PER_PASS; n++)
            send_word(random_word(), 1'b0, NO_DUTY);
         drain();
      end

      $display("Sent %0d request words over %0d register settings plus reset defaults.",
               words_sent, RANDOM_PASSES);
      $display("Checked %0d response words, %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0 && duty_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
